/* rtl/core/oft_pkg.sv */
`timescale 1ns / 1ps

package oft_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_OFFSET_X = 3'd0;
   localparam logic [2:0] CSR_OFFSET_Y = 3'd1;
   localparam logic [2:0] CSR_OFFSET_Z = 3'd2;
   localparam logic [2:0] CSR_ROTATION = 3'd3;

   localparam logic [63:0] ROTATION_RESET = 64'd16384;

   // quaternion word order inside arrays
   localparam int QW = 0;
   localparam int QX = 1;
   localparam int QY = 2;
   localparam int QZ = 3;

   // order of quaternion pair products
   localparam int PXX = 0;
   localparam int PYY = 1;
   localparam int PZZ = 2;
   localparam int PXY = 3;
   localparam int PXZ = 4;
   localparam int PYZ = 5;
   localparam int PWX = 6;
   localparam int PWY = 7;
   localparam int PWZ = 8;

   typedef logic signed [15:0] qword_type [4];
   typedef logic signed [31:0] pairs_type [9];

   // split a packed w,z,y,x quaternion
   function automatic qword_type unpack_quat(input logic [63:0] p);
      qword_type q;
      q[QX] = p[15:0];
      q[QY] = p[31:16];
      q[QZ] = p[47:32];
      q[QW] = p[63:48];
      return q;
   endfunction

   // products that the rotation matrix is built from
   function automatic pairs_type pair_products(input qword_type q);
      pairs_type r;
      r[PXX] = q[QX] * q[QX];
      r[PYY] = q[QY] * q[QY];
      r[PZZ] = q[QZ] * q[QZ];
      r[PXY] = q[QX] * q[QY];
      r[PXZ] = q[QX] * q[QZ];
      r[PYZ] = q[QY] * q[QZ];
      r[PWX] = q[QW] * q[QX];
      r[PWY] = q[QW] * q[QY];
      r[PWZ] = q[QW] * q[QZ];
      return r;
   endfunction

   // one matrix entry in Q.28, rounded half up to Q.14
   function automatic logic signed [21:0] rot_entry(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic diag,
                                                   input logic minus);
      logic signed [35:0] s;
      logic signed [35:0] r;
      s = minus ? (36'(a) - 36'(b)) : (36'(a) + 36'(b));
      r = diag ? (36'sd268435456 - (s <<< 1)) : (s <<< 1);
      r = r + 36'sd8192;
      return r[35:14];
   endfunction

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

   // clamp to the signed 16-bit range
   function automatic logic signed [15:0] sat16(input logic signed [19:0] x);
      if (x > 20'sd32767) begin
         return 16'sh7fff;
      end else if (x < -20'sd32768) begin
         return 16'sh8000;
      end
      return x[15:0];
   endfunction

endpackage

/* rtl/core/odometry_frame_transform_unit.sv */
`timescale 1ns / 1ps

// Re-expresses one odometry sample for a target frame rigidly mounted on the
// source body: position p + R(q_IS)*t, orientation q_IS*q_ST (saturated, not
// renormalized), linear velocity R(q_ST)^T*(v + w x t), angular velocity
// R(q_ST)^T*w; vectors are Q16.16 and quaternion words Q.14, all saturated. The
// datapath is a five register pipeline (input, products, matrix/cross/quaternion
// sums, matrix products, output sums): one item is accepted every cycle while
// req_stall is low, and a stage holds its item only while every later stage is
// full and the output is stalled. The mount registers are read by the pipeline
// directly, so write them only while no item is in flight.
module odometry_frame_transform_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_src_pos_x,
   input  logic signed [31:0] req_src_pos_y,
   input  logic signed [31:0] req_src_pos_z,
   input  logic        [63:0] req_src_orientation,
   input  logic signed [31:0] req_src_lin_vel_x,
   input  logic signed [31:0] req_src_lin_vel_y,
   input  logic signed [31:0] req_src_lin_vel_z,
   input  logic signed [31:0] req_src_ang_vel_x,
   input  logic signed [31:0] req_src_ang_vel_y,
   input  logic signed [31:0] req_src_ang_vel_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_tgt_pos_x,
   output logic signed [31:0] rsp_tgt_pos_y,
   output logic signed [31:0] rsp_tgt_pos_z,
   output logic        [63:0] rsp_tgt_orientation,
   output logic signed [31:0] rsp_tgt_lin_vel_x,
   output logic signed [31:0] rsp_tgt_lin_vel_y,
   output logic signed [31:0] rsp_tgt_lin_vel_z,
   output logic signed [31:0] rsp_tgt_ang_vel_x,
   output logic signed [31:0] rsp_tgt_ang_vel_y,
   output logic signed [31:0] rsp_tgt_ang_vel_z,
   input  logic               csr_write_en,
   input  logic        [2:0]  csr_index,
   input  logic        [63:0] csr_data
);

   // mount registers
   logic signed [31:0] offset_ff [3];
   logic        [63:0] rotation_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff[0] <= '0;
         offset_ff[1] <= '0;
         offset_ff[2] <= '0;
         rotation_ff  <= oft_pkg::ROTATION_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            oft_pkg::CSR_OFFSET_X: offset_ff[0] <= csr_data[31:0];
            oft_pkg::CSR_OFFSET_Y: offset_ff[1] <= csr_data[31:0];
            oft_pkg::CSR_OFFSET_Z: offset_ff[2] <= csr_data[31:0];
            oft_pkg::CSR_ROTATION: rotation_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // stage flow control: a stage loads when it is empty or its item moves on
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, rsp_v_ff;
   logic free_out, free4, free3, free2, free1;

   assign free_out  = !rsp_v_ff || !rsp_stall;
   assign free4     = !s4_v_ff || free_out;
   assign free3     = !s3_v_ff || free4;
   assign free2     = !s2_v_ff || free3;
   assign free1     = !s1_v_ff || free2;
   assign req_stall = !free1;
   assign rsp_valid = rsp_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (free1)    s1_v_ff  <= req_valid;
         if (free2)    s2_v_ff  <= s1_v_ff;
         if (free3)    s3_v_ff  <= s2_v_ff;
         if (free4)    s4_v_ff  <= s3_v_ff;
         if (free_out) rsp_v_ff <= s4_v_ff;
      end
   end

   // stage 1: capture the item
   logic signed [31:0] s1_pos_ff [3];
   logic signed [31:0] s1_vel_ff [3];
   logic signed [31:0] s1_ang_ff [3];
   logic        [63:0] s1_quat_ff;

   always_ff @(posedge clock) begin
      if (free1) begin
         s1_pos_ff[0] <= req_src_pos_x;
         s1_pos_ff[1] <= req_src_pos_y;
         s1_pos_ff[2] <= req_src_pos_z;
         s1_vel_ff[0] <= req_src_lin_vel_x;
         s1_vel_ff[1] <= req_src_lin_vel_y;
         s1_vel_ff[2] <= req_src_lin_vel_z;
         s1_ang_ff[0] <= req_src_ang_vel_x;
         s1_ang_ff[1] <= req_src_ang_vel_y;
         s1_ang_ff[2] <= req_src_ang_vel_z;
         s1_quat_ff   <= req_src_orientation;
      end
   end

   // stage 2: all first-level products
   oft_pkg::qword_type qi_w, qs_w;
   oft_pkg::pairs_type qi_pairs_in, qs_pairs_in;
   logic signed [31:0] ham_in [16];
   logic signed [63:0] cross_in [6];

   always_comb begin
      qi_w        = oft_pkg::unpack_quat(s1_quat_ff);
      qs_w        = oft_pkg::unpack_quat(rotation_ff);
      qi_pairs_in = oft_pkg::pair_products(qi_w);
      qs_pairs_in = oft_pkg::pair_products(qs_w);
      for (int a = 0; a < 4; a++) begin
         for (int b = 0; b < 4; b++) begin
            ham_in[a * 4 + b] = qi_w[a] * qs_w[b];
         end
      end
      cross_in[0] = s1_ang_ff[1] * offset_ff[2];
      cross_in[1] = s1_ang_ff[2] * offset_ff[1];
      cross_in[2] = s1_ang_ff[2] * offset_ff[0];
      cross_in[3] = s1_ang_ff[0] * offset_ff[2];
      cross_in[4] = s1_ang_ff[0] * offset_ff[1];
      cross_in[5] = s1_ang_ff[1] * offset_ff[0];
   end

   oft_pkg::pairs_type s2_qi_ff, s2_qs_ff;
   logic signed [31:0] s2_ham_ff [16];
   logic signed [63:0] s2_cross_ff [6];
   logic signed [31:0] s2_pos_ff [3];
   logic signed [31:0] s2_vel_ff [3];
   logic signed [31:0] s2_ang_ff [3];

   always_ff @(posedge clock) begin
      if (free2) begin
         s2_qi_ff    <= qi_pairs_in;
         s2_qs_ff    <= qs_pairs_in;
         s2_ham_ff   <= ham_in;
         s2_cross_ff <= cross_in;
         s2_pos_ff   <= s1_pos_ff;
         s2_vel_ff   <= s1_vel_ff;
         s2_ang_ff   <= s1_ang_ff;
      end
   end

   // stage 3: rotation matrices, v + w x t, output quaternion
   logic signed [21:0] ri_in [9];
   logic signed [21:0] rs_in [9];
   logic signed [31:0] u_in [3];
   logic signed [15:0] qo_in [4];

   always_comb begin
      logic signed [47:0] cr [6];
      logic signed [63:0] rnd;
      logic signed [49:0] us;
      logic signed [33:0] qs;
      // rotation matrix entries, row-major
      ri_in[0] = oft_pkg::rot_entry(s2_qi_ff[oft_pkg::PYY], s2_qi_ff[oft_pkg::PZZ], 1'b1, 1'b0);
      ri_in[1] = oft_pkg::rot_entry(s2_qi_ff[oft_pkg::PXY], s2_qi_ff[oft_pkg::PWZ], 1'b0, 1'b1);
      ri_in[2] = oft_pkg::rot_entry(s2_qi_ff[oft_pkg::PXZ], s2_qi_ff[oft_pkg::PWY], 1'b0, 1'b0);
      ri_in[3] = oft_pkg::rot_entry(s2_qi_ff[oft_pkg::PXY], s2_qi_ff[oft_pkg::PWZ], 1'b0, 1'b0);
      ri_in[4] = oft_pkg::rot_entry(s2_qi_ff[oft_pkg::PXX], s2_qi_ff[oft_pkg::PZZ], 1'b1, 1'b0);
      ri_in[5] = oft_pkg::rot_entry(s2_qi_ff[oft_pkg::PYZ], s2_qi_ff[oft_pkg::PWX], 1'b0, 1'b1);
      ri_in[6] = oft_pkg::rot_entry(s2_qi_ff[oft_pkg::PXZ], s2_qi_ff[oft_pkg::PWY], 1'b0, 1'b1);
      ri_in[7] = oft_pkg::rot_entry(s2_qi_ff[oft_pkg::PYZ], s2_qi_ff[oft_pkg::PWX], 1'b0, 1'b0);
      ri_in[8] = oft_pkg::rot_entry(s2_qi_ff[oft_pkg::PXX], s2_qi_ff[oft_pkg::PYY], 1'b1, 1'b0);
      rs_in[0] = oft_pkg::rot_entry(s2_qs_ff[oft_pkg::PYY], s2_qs_ff[oft_pkg::PZZ], 1'b1, 1'b0);
      rs_in[1] = oft_pkg::rot_entry(s2_qs_ff[oft_pkg::PXY], s2_qs_ff[oft_pkg::PWZ], 1'b0, 1'b1);
      rs_in[2] = oft_pkg::rot_entry(s2_qs_ff[oft_pkg::PXZ], s2_qs_ff[oft_pkg::PWY], 1'b0, 1'b0);
      rs_in[3] = oft_pkg::rot_entry(s2_qs_ff[oft_pkg::PXY], s2_qs_ff[oft_pkg::PWZ], 1'b0, 1'b0);
      rs_in[4] = oft_pkg::rot_entry(s2_qs_ff[oft_pkg::PXX], s2_qs_ff[oft_pkg::PZZ], 1'b1, 1'b0);
      rs_in[5] = oft_pkg::rot_entry(s2_qs_ff[oft_pkg::PYZ], s2_qs_ff[oft_pkg::PWX], 1'b0, 1'b1);
      rs_in[6] = oft_pkg::rot_entry(s2_qs_ff[oft_pkg::PXZ], s2_qs_ff[oft_pkg::PWY], 1'b0, 1'b1);
      rs_in[7] = oft_pkg::rot_entry(s2_qs_ff[oft_pkg::PYZ], s2_qs_ff[oft_pkg::PWX], 1'b0, 1'b0);
      rs_in[8] = oft_pkg::rot_entry(s2_qs_ff[oft_pkg::PXX], s2_qs_ff[oft_pkg::PYY], 1'b1, 1'b0);

      // round each cross term to Q16.16
      for (int i = 0; i < 6; i++) begin
         rnd   = s2_cross_ff[i] + 64'sd32768;
         cr[i] = rnd[63:16];
      end
      for (int i = 0; i < 3; i++) begin
         us      = 50'(s2_vel_ff[i]) + 50'(cr[2 * i]) - 50'(cr[2 * i + 1]);
         u_in[i] = oft_pkg::sat32(64'(us));
      end

      // Hamilton product, index a*4+b for source word a and mount word b
      qs = 34'(s2_ham_ff[0]) - 34'(s2_ham_ff[5]) - 34'(s2_ham_ff[10]) - 34'(s2_ham_ff[15]);
      qs = qs + 34'sd8192;
      qo_in[oft_pkg::QW] = oft_pkg::sat16(qs[33:14]);
      qs = 34'(s2_ham_ff[1]) + 34'(s2_ham_ff[4]) + 34'(s2_ham_ff[11]) - 34'(s2_ham_ff[14]);
      qs = qs + 34'sd8192;
      qo_in[oft_pkg::QX] = oft_pkg::sat16(qs[33:14]);
      qs = 34'(s2_ham_ff[2]) - 34'(s2_ham_ff[7]) + 34'(s2_ham_ff[8]) + 34'(s2_ham_ff[13]);
      qs = qs + 34'sd8192;
      qo_in[oft_pkg::QY] = oft_pkg::sat16(qs[33:14]);
      qs = 34'(s2_ham_ff[3]) + 34'(s2_ham_ff[6]) - 34'(s2_ham_ff[9]) + 34'(s2_ham_ff[12]);
      qs = qs + 34'sd8192;
      qo_in[oft_pkg::QZ] = oft_pkg::sat16(qs[33:14]);
   end

   logic signed [21:0] s3_ri_ff [9];
   logic signed [21:0] s3_rs_ff [9];
   logic signed [31:0] s3_u_ff [3];
   logic        [63:0] s3_quat_ff;
   logic signed [31:0] s3_pos_ff [3];
   logic signed [31:0] s3_ang_ff [3];

   always_ff @(posedge clock) begin
      if (free3) begin
         s3_ri_ff   <= ri_in;
         s3_rs_ff   <= rs_in;
         s3_u_ff    <= u_in;
         s3_quat_ff <= {qo_in[oft_pkg::QW], qo_in[oft_pkg::QZ],
                        qo_in[oft_pkg::QY], qo_in[oft_pkg::QX]};
         s3_pos_ff  <= s2_pos_ff;
         s3_ang_ff  <= s2_ang_ff;
      end
   end

   // stage 4: matrix-vector products, element [i*3+j] feeds output row i
   logic signed [53:0] pp_in [9];
   logic signed [53:0] lp_in [9];
   logic signed [53:0] ap_in [9];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pp_in[i * 3 + j] = s3_ri_ff[i * 3 + j] * offset_ff[j];
            lp_in[i * 3 + j] = s3_rs_ff[j * 3 + i] * s3_u_ff[j];
            ap_in[i * 3 + j] = s3_rs_ff[j * 3 + i] * s3_ang_ff[j];
         end
      end
   end

   logic signed [53:0] s4_pp_ff [9];
   logic signed [53:0] s4_lp_ff [9];
   logic signed [53:0] s4_ap_ff [9];
   logic        [63:0] s4_quat_ff;
   logic signed [31:0] s4_pos_ff [3];

   always_ff @(posedge clock) begin
      if (free4) begin
         s4_pp_ff   <= pp_in;
         s4_lp_ff   <= lp_in;
         s4_ap_ff   <= ap_in;
         s4_quat_ff <= s3_quat_ff;
         s4_pos_ff  <= s3_pos_ff;
      end
   end

   // stage 5: row sums, rounding, saturation
   logic signed [31:0] pos_in [3];
   logic signed [31:0] lin_in [3];
   logic signed [31:0] ang_in [3];

   always_comb begin
      logic signed [55:0] sp, sl, sa;
      logic signed [41:0] rp;
      for (int i = 0; i < 3; i++) begin
         sp = 56'(s4_pp_ff[i * 3]) + 56'(s4_pp_ff[i * 3 + 1]) + 56'(s4_pp_ff[i * 3 + 2]);
         sl = 56'(s4_lp_ff[i * 3]) + 56'(s4_lp_ff[i * 3 + 1]) + 56'(s4_lp_ff[i * 3 + 2]);
         sa = 56'(s4_ap_ff[i * 3]) + 56'(s4_ap_ff[i * 3 + 1]) + 56'(s4_ap_ff[i * 3 + 2]);
         sp = sp + 56'sd8192;
         sl = sl + 56'sd8192;
         sa = sa + 56'sd8192;
         rp = sp[55:14];
         pos_in[i] = oft_pkg::sat32(64'(rp) + 64'(s4_pos_ff[i]));
         lin_in[i] = oft_pkg::sat32(64'($signed(sl[55:14])));
         ang_in[i] = oft_pkg::sat32(64'($signed(sa[55:14])));
      end
   end

   logic signed [31:0] out_pos_ff [3];
   logic signed [31:0] out_lin_ff [3];
   logic signed [31:0] out_ang_ff [3];
   logic        [63:0] out_quat_ff;

   always_ff @(posedge clock) begin
      if (free_out) begin
         out_pos_ff  <= pos_in;
         out_lin_ff  <= lin_in;
         out_ang_ff  <= ang_in;
         out_quat_ff <= s4_quat_ff;
      end
   end

   assign rsp_tgt_pos_x       = out_pos_ff[0];
   assign rsp_tgt_pos_y       = out_pos_ff[1];
   assign rsp_tgt_pos_z       = out_pos_ff[2];
   assign rsp_tgt_orientation = out_quat_ff;
   assign rsp_tgt_lin_vel_x   = out_lin_ff[0];
   assign rsp_tgt_lin_vel_y   = out_lin_ff[1];
   assign rsp_tgt_lin_vel_z   = out_lin_ff[2];
   assign rsp_tgt_ang_vel_x   = out_ang_ff[0];
   assign rsp_tgt_ang_vel_y   = out_ang_ff[1];
   assign rsp_tgt_ang_vel_z   = out_ang_ff[2];

endmodule
